>>> rtl/lrufr_pkg.sv
// Shared types, codes and constants of the LRU frame replacer.
package lrufr_pkg;

   localparam int unsigned FRAMES_DEF = 64;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned FRAME_W    = 6;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned FRAME_MAX  = (1 << FRAME_W) - 1;

   typedef enum logic [FUNC_W-1:0] {
      FN_VICTIM = 2'd0,
      FN_PIN    = 2'd1,
      FN_UNPIN  = 2'd2,
      FN_NOP    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK        = 2'd0,
      RS_NO_VICTIM = 2'd1,
      RS_UNTRACKED = 2'd2
   } status_type;

   // Operation broadcast to every cell while a token walks the chain.
   typedef enum logic [2:0] {
      CMD_INS   = 3'd0,   // insert at newest end, drop an older copy
      CMD_FIND  = 3'd1,   // look up a frame
      CMD_MARK  = 3'd2,   // look up a frame and mark it evictable
      CMD_VSCAN = 3'd3,   // carry the oldest evictable frame to the tail
      CMD_PULL  = 3'd4    // remove a frame and close the gap
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [FRAME_W-1:0] frame;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  victim_frame;
      logic [COUNT_W-1:0]  evictable_count;
   } rsp_type;

   // One recency list entry held by a cell.
   typedef struct packed {
      logic               valid;
      logic               ev;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   // Token handed from cell to cell, with the item or result it carries.
   typedef struct packed {
      logic               live;
      logic               act;
      logic               hit;
      logic               flag;
      logic               ev;
      logic [FRAME_W-1:0] frame;
   } tok_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [FRAME_W-1:0] key;
   } ctl_type;

endpackage

>>> rtl/lrufr_cell.sv
// One recency list cell: holds an entry and acts on the passing token.
module lrufr_cell (
   input  logic                clock,
   input  logic                reset,
   input  lrufr_pkg::ctl_type  ctl,
   input  lrufr_pkg::tok_type  tok_in,
   input  lrufr_pkg::entry_type right_in,
   output lrufr_pkg::tok_type  tok_out,
   output lrufr_pkg::entry_type entry_out
);
   import lrufr_pkg::*;

   entry_type ent_ff, ent_in;
   tok_type   tok_ff;
   logic      match;

   assign match     = ent_ff.valid && (ent_ff.frame == ctl.key);
   assign entry_out = ent_ff;

   always_comb begin
      ent_in  = ent_ff;
      tok_out = tok_ff;
      if (tok_ff.live && tok_ff.act) begin
         unique case (ctl.cmd)
            CMD_INS: begin
               // take the carried entry, hand the old one on
               ent_in.valid = 1'b1;
               ent_in.ev    = tok_ff.ev;
               ent_in.frame = tok_ff.frame;
               if (!ent_ff.valid) begin
                  tok_out.act = 1'b0;
                  tok_out.hit = 1'b0;
               end else if (match) begin
                  tok_out.act  = 1'b0;
                  tok_out.hit  = 1'b1;
                  tok_out.flag = ent_ff.ev;
               end else begin
                  tok_out.ev    = ent_ff.ev;
                  tok_out.frame = ent_ff.frame;
               end
            end
            CMD_FIND, CMD_MARK: begin
               if (!ent_ff.valid) begin
                  tok_out.act = 1'b0;
               end else if (match) begin
                  tok_out.act  = 1'b0;
                  tok_out.hit  = 1'b1;
                  tok_out.flag = ent_ff.ev;
                  if (ctl.cmd == CMD_MARK) begin
                     ent_in.ev = 1'b1;
                  end
               end
            end
            CMD_VSCAN: begin
               if (!ent_ff.valid) begin
                  tok_out.act = 1'b0;
               end else if (ent_ff.ev) begin
                  tok_out.hit   = 1'b1;
                  tok_out.frame = ent_ff.frame;
               end
            end
            CMD_PULL: begin
               if (tok_ff.hit || match) begin
                  ent_in      = right_in;
                  tok_out.hit = 1'b1;
               end
            end
            default: begin
               tok_out.act = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         tok_ff <= '0;
      end else begin
         ent_ff <= ent_in;
         tok_ff <= tok_in;
      end
   end

endmodule

>>> rtl/lrufr_ctrl.sv
// Sequencer: accepts transactions, launches chain passes, keeps counts.
module lrufr_ctrl #(
   parameter int unsigned FRAMES = lrufr_pkg::FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lrufr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lrufr_pkg::rsp_type rsp_data,
   output lrufr_pkg::ctl_type ctl,
   output lrufr_pkg::tok_type inj,
   input  lrufr_pkg::tok_type tail
);
   import lrufr_pkg::*;

   localparam int unsigned LEN_W = $clog2(FRAMES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PASS = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [FRAME_W-1:0] key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   total_ff, total_in;
   status_type         res_st_ff, res_st_in;
   logic [FRAME_W-1:0] res_vf_ff, res_vf_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               frame_bad;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign ctl.cmd   = cmd_ff;
   assign ctl.key   = key_ff;

   // Frames at or above the pool size are never tracked.
   assign frame_bad = (FRAMES <= FRAME_MAX) && (req_data.frame >= FRAME_W'(FRAMES));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      res_st_in    = res_st_ff;
      res_vf_in    = res_vf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      inj          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in    = req_data.frame;
               res_st_in = RS_OK;
               res_vf_in = '0;
               state_in  = ST_DONE;
               inj.frame = req_data.frame;
               inj.act   = 1'b1;
               unique case (req_data.func)
                  FN_VICTIM: begin
                     if (total_ff == '0) begin
                        res_st_in = RS_NO_VICTIM;
                     end else begin
                        cmd_in   = CMD_VSCAN;
                        inj.live = 1'b1;
                        state_in = ST_PASS;
                     end
                  end
                  FN_PIN: begin
                     if (!frame_bad) begin
                        cmd_in   = (len_ff == LEN_W'(FRAMES)) ? CMD_FIND : CMD_INS;
                        inj.live = 1'b1;
                        state_in = ST_PASS;
                     end
                  end
                  FN_UNPIN: begin
                     if (frame_bad) begin
                        res_st_in = RS_UNTRACKED;
                     end else begin
                        cmd_in   = CMD_MARK;
                        inj.live = 1'b1;
                        state_in = ST_PASS;
                     end
                  end
                  default: begin
                     res_st_in = RS_OK;
                  end
               endcase
            end
         end
         ST_PASS: begin
            if (tail.live) begin
               state_in = ST_DONE;
               unique case (cmd_ff)
                  CMD_VSCAN: begin
                     key_in    = tail.frame;
                     cmd_in    = CMD_PULL;
                     inj.live  = 1'b1;
                     inj.act   = 1'b1;
                     state_in  = ST_PASS;
                  end
                  CMD_PULL: begin
                     res_vf_in = key_ff;
                     total_in  = total_ff - LEN_W'(1);
                     len_in    = len_ff - LEN_W'(1);
                  end
                  CMD_FIND: begin
                     if (tail.hit) begin
                        cmd_in    = CMD_INS;
                        inj.live  = 1'b1;
                        inj.act   = 1'b1;
                        inj.frame = key_ff;
                        state_in  = ST_PASS;
                     end
                  end
                  CMD_MARK: begin
                     if (!tail.hit) begin
                        res_st_in = RS_UNTRACKED;
                     end else if (!tail.flag) begin
                        total_in = total_ff + LEN_W'(1);
                     end
                  end
                  CMD_INS: begin
                     if (tail.hit) begin
                        if (tail.flag && (total_ff != '0)) begin
                           total_in = total_ff - LEN_W'(1);
                        end
                     end else begin
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status          = res_st_ff;
               rsp_in.victim_frame    = res_vf_ff;
               rsp_in.evictable_count = COUNT_W'(total_ff);
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= CMD_FIND;
         len_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      res_st_ff <= res_st_in;
      res_vf_ff <= res_vf_in;
      rsp_ff    <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_total_le_len: assert property (@(posedge clock) disable iff (reset)
      total_ff <= len_ff)
      else $error("evictable count exceeds list length");

   a_len_le_frames: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(FRAMES))
      else $error("list length exceeds frame count");

   a_tail_in_pass: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> (state_ff == ST_PASS))
      else $error("token left the chain outside a pass");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("sequencer not busy after a transaction");
`endif

endmodule

>>> rtl/lru_frame_replacer_core.sv
// Top level of the LRU frame replacer: sequencer and chain of list cells.
//
// Usage: one request channel (req_valid, req_stall, req_data) carries a
// transaction with func (victim, pin, unpin) and a frame number; one response
// channel (rsp_valid, rsp_stall, rsp_data) returns exactly one transaction per
// request with status, victim frame and the evictable count after the request.
// The recency list lives in a row of FRAMES cells, newest at cell 0. Each
// pass sends one token from cell 0 to the last cell, one cell per cycle.
// An unpin takes a mark pass and a pin an insert pass; a pin while the list
// is full takes a lookup pass, then an insert pass if the frame is found; a
// successful victim takes a scan pass, then a removal pass; the requests
// answered at once need no pass. One transaction is in work at a time, so
// the chain length sets the throughput. Reset empties the list and the
// counts. A stalled response holds in its output register; a finished
// result then waits in the sequencer and further requests see req_stall.
module lru_frame_replacer_core #(
   parameter int unsigned FRAMES = lrufr_pkg::FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lrufr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lrufr_pkg::rsp_type rsp_data
);
   import lrufr_pkg::*;

   ctl_type   ctl;
   tok_type   tok_chain [FRAMES+1];
   entry_type ent_chain [FRAMES];

   lrufr_ctrl #(
      .FRAMES (FRAMES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .inj       (tok_chain[0]),
      .tail      (tok_chain[FRAMES])
   );

   // Each cell hands its token to the next older cell and, during removal,
   // pulls its older neighbor's entry; the last cell pulls an empty entry.
   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      entry_type right;
      if (i == FRAMES - 1) begin : g_last
         assign right = '0;
      end else begin : g_mid
         assign right = ent_chain[i+1];
      end

      lrufr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .tok_in    (tok_chain[i]),
         .right_in  (right),
         .tok_out   (tok_chain[i+1]),
         .entry_out (ent_chain[i])
      );
   end

endmodule
